/* sv/gne_pkg.sv */
// Shared types, constants and neighbour tables for the grid neighbour expander.
`default_nettype none

package gne_pkg;

  // Largest grid side held in storage by default
  localparam int unsigned GNE_MAX_DIM = 256;

  // Configuration port
  localparam int unsigned GNE_PADDR_W = 5;
  localparam int unsigned GNE_PDATA_W = 32;

  // Register reset values
  localparam logic [8:0] GNE_RST_GRID_WIDTH    = 9'd256;
  localparam logic [8:0] GNE_RST_GRID_HEIGHT   = 9'd256;
  localparam logic       GNE_RST_DIAG_ENABLE   = 1'b1;
  localparam logic [7:0] GNE_RST_STRAIGHT_COST = 8'd10;
  localparam logic [7:0] GNE_RST_DIAGONAL_COST = 8'd14;

  // Item kinds
  localparam logic GNE_KIND_WRITE  = 1'b0;
  localparam logic GNE_KIND_EXPAND = 1'b1;

  // Map byte that marks a cell as blocked
  localparam logic [7:0] GNE_BLOCKED_CODE = 8'd1;

  // Neighbour offsets as 9-bit two's complement: right, down, left, up,
  // down-right, down-left, up-left, up-right
  localparam logic [8:0] GNE_DX [8] = '{9'd1, 9'd0, 9'h1FF, 9'd0,
                                        9'd1, 9'h1FF, 9'h1FF, 9'd1};
  localparam logic [8:0] GNE_DY [8] = '{9'd0, 9'd1, 9'd0, 9'h1FF,
                                        9'd1, 9'd1, 9'h1FF, 9'h1FF};

  typedef struct packed {
    logic       kind;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [7:0] cell_value;
    logic [7:0] target_x;
    logic [7:0] target_y;
  } gne_req_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  neighbor_x;
    logic [7:0]  neighbor_y;
    logic [7:0]  step_cost;
    logic [16:0] estimate;
    logic        last;
  } gne_rsp_t;

  typedef struct packed {
    logic [8:0] grid_width;
    logic [8:0] grid_height;
    logic       diagonal_enable;
    logic [7:0] straight_cost;
    logic [7:0] diagonal_cost;
  } gne_cfg_t;

endpackage

`default_nettype wire

/* sv/gne_req_if.sv */
// Valid/ready channel carrying request words into the expander.
`default_nettype none

interface gne_req_if import gne_pkg::*; ();
  logic     valid;
  logic     ready;
  gne_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/gne_rsp_if.sv */
// Valid/ready channel carrying result words out of the expander.
`default_nettype none

interface gne_rsp_if import gne_pkg::*; ();
  logic     valid;
  logic     ready;
  gne_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/gne_cfg_regs.sv */
// APB-style configuration register bank for the grid neighbour expander.
`default_nettype none

module gne_cfg_regs import gne_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [GNE_PADDR_W-1:0] paddr,
  input  logic [GNE_PDATA_W-1:0] pwdata,
  output logic [GNE_PDATA_W-1:0] prdata,
  output logic                   pready,
  output gne_cfg_t               cfg_o
);

  typedef enum logic [2:0] {
    REG_GRID_WIDTH    = 3'd0,
    REG_GRID_HEIGHT   = 3'd1,
    REG_DIAG_ENABLE   = 3'd2,
    REG_STRAIGHT_COST = 3'd3,
    REG_DIAGONAL_COST = 3'd4
  } gne_reg_e;

  gne_cfg_t   cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width      <= GNE_RST_GRID_WIDTH;
      cfg_q.grid_height     <= GNE_RST_GRID_HEIGHT;
      cfg_q.diagonal_enable <= GNE_RST_DIAG_ENABLE;
      cfg_q.straight_cost   <= GNE_RST_STRAIGHT_COST;
      cfg_q.diagonal_cost   <= GNE_RST_DIAGONAL_COST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:    cfg_q.grid_width      <= pwdata[8:0];
        REG_GRID_HEIGHT:   cfg_q.grid_height     <= pwdata[8:0];
        REG_DIAG_ENABLE:   cfg_q.diagonal_enable <= pwdata[0];
        REG_STRAIGHT_COST: cfg_q.straight_cost   <= pwdata[7:0];
        REG_DIAGONAL_COST: cfg_q.diagonal_cost   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_WIDTH:    prdata = {23'd0, cfg_q.grid_width};
      REG_GRID_HEIGHT:   prdata = {23'd0, cfg_q.grid_height};
      REG_DIAG_ENABLE:   prdata = {31'd0, cfg_q.diagonal_enable};
      REG_STRAIGHT_COST: prdata = {24'd0, cfg_q.straight_cost};
      REG_DIAGONAL_COST: prdata = {24'd0, cfg_q.diagonal_cost};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/grid_neighbor_expander.sv */
// Top level: bit-grid store and eight-way neighbour expansion sequencer.
//
//  channel   direction  handshake        word
//  req_i     in         valid/ready      kind, cell, map byte, target
//  rsp_o     out        valid/ready      found, neighbour, step cost, estimate, last
//  apb       in         psel/penable     register write/read, pready tied high
//
//  A write word is taken in the idle state.
//  An expand word makes eight grid reads, one per cycle through the single read
//  port of the map memory, then per result a select step and a multiply step
//  into the output register; when none is open it makes one empty result.
//  No clearing pass after reset: the map is undefined until written.
//  A stalled consumer holds the sequencer at the multiply step; the final
//  result waits in the output register while the next word is accepted.
`default_nettype none

module grid_neighbor_expander import gne_pkg::*; #(
  parameter int unsigned MAX_DIM = GNE_MAX_DIM
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  gne_req_if.sink                req_i,
  gne_rsp_if.source              rsp_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [GNE_PADDR_W-1:0] paddr,
  input  logic [GNE_PDATA_W-1:0] pwdata,
  output logic [GNE_PDATA_W-1:0] prdata,
  output logic                   pready
);

  // Coordinates are eight bits, so no side beyond 256 is ever reachable
  localparam int unsigned UseDim  = (MAX_DIM > 256) ? 256 : MAX_DIM;
  localparam int unsigned DimW    = $clog2(UseDim);
  localparam int unsigned AddrW   = 2 * DimW;
  localparam int unsigned Depth   = 1 << AddrW;
  localparam logic [8:0]  UseDim9 = 9'(UseDim);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_GATE,
    ST_SEL,
    ST_MUL
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  gne_cfg_t cfg;

  gne_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Usable extent: the smaller of the register and the stored side
  logic [8:0] ext_w, ext_h;
  assign ext_w = (cfg.grid_width  > UseDim9) ? UseDim9 : cfg.grid_width;
  assign ext_h = (cfg.grid_height > UseDim9) ? UseDim9 : cfg.grid_height;

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  state_e      state_q;
  logic [7:0]  cx_q, cy_q, tx_q, ty_q;
  logic [2:0]  k_q;
  logic        rd_pend_q;
  logic        rd_inr_q;
  logic [2:0]  rd_k_q;
  logic [7:0]  raw_q;      // open bits before diagonal gating
  logic [7:0]  rem_q;      // open neighbours still to emit
  logic [7:0]  nx_q, ny_q;
  logic [7:0]  cost_q;
  logic [8:0]  sum_q;
  logic        found_q;
  logic        last_q;
  logic        rsp_valid_q;
  gne_rsp_t    rsp_data_q;

  // Map memory
  logic        grid_mem_q [Depth];
  logic        rd_data_q;

  // ---------------------------------------------------------------------
  // Input side: writes go straight to the map, expands start a scan
  // ---------------------------------------------------------------------
  logic             req_acc;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid & req_i.ready;
  assign wr_en       = req_acc && (req_i.data.kind == GNE_KIND_WRITE) &&
                       ({1'b0, req_i.data.cell_x} < UseDim9) &&
                       ({1'b0, req_i.data.cell_y} < UseDim9);
  assign wr_addr     = {req_i.data.cell_x[DimW-1:0], req_i.data.cell_y[DimW-1:0]};

  // Neighbour under scan; a step off either edge wraps to 511 or lands on
  // 256, both beyond any extent
  logic [8:0]       rd_nx, rd_ny;
  logic             rd_inr;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;

  assign rd_nx   = {1'b0, cx_q} + GNE_DX[k_q];
  assign rd_ny   = {1'b0, cy_q} + GNE_DY[k_q];
  assign rd_inr  = (rd_nx < ext_w) && (rd_ny < ext_h);
  assign rd_en   = (state_q == ST_READ) && rd_inr;
  assign rd_addr = {rd_nx[DimW-1:0], rd_ny[DimW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_mem_q[wr_addr] <= (req_i.data.cell_value == GNE_BLOCKED_CODE);
    end
    if (rd_en) begin
      rd_data_q <= grid_mem_q[rd_addr];
    end
  end

  // Diagonals need diagonals enabled and both flanking orthogonals open
  logic [7:0] gated;
  always_comb begin
    gated[3:0] = raw_q[3:0];
    gated[4]   = raw_q[4] & cfg.diagonal_enable & raw_q[0] & raw_q[1];
    gated[5]   = raw_q[5] & cfg.diagonal_enable & raw_q[2] & raw_q[1];
    gated[6]   = raw_q[6] & cfg.diagonal_enable & raw_q[2] & raw_q[3];
    gated[7]   = raw_q[7] & cfg.diagonal_enable & raw_q[0] & raw_q[3];
  end

  // Lowest open neighbour still pending
  logic [2:0] sel_k;
  always_comb begin
    sel_k = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rem_q[i]) begin
        sel_k = 3'(i);
      end
    end
  end

  logic [7:0] sel_nx, sel_ny;
  logic [7:0] dist_x, dist_y;
  logic [7:0] sel_rem;
  logic [8:0] sel_nx9, sel_ny9;

  assign sel_nx9 = {1'b0, cx_q} + GNE_DX[sel_k];
  assign sel_ny9 = {1'b0, cy_q} + GNE_DY[sel_k];
  assign sel_nx  = sel_nx9[7:0];
  assign sel_ny  = sel_ny9[7:0];
  assign dist_x  = (tx_q > sel_nx) ? (tx_q - sel_nx) : (sel_nx - tx_q);
  assign dist_y  = (ty_q > sel_ny) ? (ty_q - sel_ny) : (sel_ny - ty_q);
  assign sel_rem = rem_q & ~(8'd1 << sel_k);

  logic        out_free;
  logic [16:0] est;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign est      = 17'(sum_q) * 17'(cfg.straight_cost);

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

  // ---------------------------------------------------------------------
  // Sequencer: state and registered outputs
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= 3'd0;
      rd_pend_q   <= 1'b0;
      rd_inr_q    <= 1'b0;
      rd_k_q      <= 3'd0;
      raw_q       <= '0;
      rem_q       <= '0;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      // Load a word from the multiply step, or retire a taken one
      if ((state_q == ST_MUL) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      // Collect the read issued in the previous cycle
      rd_pend_q <= (state_q == ST_READ);
      rd_inr_q  <= rd_inr;
      rd_k_q    <= k_q;
      if (rd_pend_q) begin
        raw_q[rd_k_q] <= rd_inr_q & ~rd_data_q;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_acc && (req_i.data.kind == GNE_KIND_EXPAND)) begin
            cx_q    <= req_i.data.cell_x;
            cy_q    <= req_i.data.cell_y;
            tx_q    <= req_i.data.target_x;
            ty_q    <= req_i.data.target_y;
            k_q     <= 3'd0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd7) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_GATE;
        end
        ST_GATE: begin
          rem_q   <= gated;
          state_q <= ST_SEL;
        end
        ST_SEL: begin
          if (rem_q != 8'd0) begin
            found_q <= 1'b1;
            nx_q    <= sel_nx;
            ny_q    <= sel_ny;
            cost_q  <= sel_k[2] ? cfg.diagonal_cost : cfg.straight_cost;
            sum_q   <= {1'b0, dist_x} + {1'b0, dist_y};
            last_q  <= (sel_rem == 8'd0);
            rem_q   <= sel_rem;
          end else begin
            // Nothing open: one empty word closes the item
            found_q <= 1'b0;
            nx_q    <= 8'd0;
            ny_q    <= 8'd0;
            cost_q  <= 8'd0;
            sum_q   <= 9'd0;
            last_q  <= 1'b1;
          end
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (out_free) begin
            rsp_data_q.found      <= found_q;
            rsp_data_q.neighbor_x <= nx_q;
            rsp_data_q.neighbor_y <= ny_q;
            rsp_data_q.step_cost  <= cost_q;
            rsp_data_q.estimate   <= est;
            rsp_data_q.last       <= last_q;
            state_q               <= last_q ? ST_IDLE : ST_SEL;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_empty_word_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_data_q.found) |->
      (rsp_data_q.last && rsp_data_q.neighbor_x == 8'd0 &&
       rsp_data_q.neighbor_y == 8'd0 && rsp_data_q.step_cost == 8'd0 &&
       rsp_data_q.estimate == 17'd0))
    else $error("empty result word is not a clean final word");

  a_expand_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.data.kind == GNE_KIND_EXPAND) |=>
      (state_q == ST_READ && k_q == 3'd0))
    else $error("expand word did not start the neighbour scan");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && out_free && last_q) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after the final word");

  a_read_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_READ || state_q == ST_DRAIN))
    else $error("map read data arrived outside the scan");

endmodule

`default_nettype wire

/* verif/tb_grid_neighbor_expander.sv */
// Self-checking testbench for the grid neighbour expander: directed corners, gating, registers.
`timescale 1ns / 100ps

// Structure of the bench
//   - One sender task pushes request words through the valid/ready channel and,
//     on the edge where a word is taken, feeds it to the local predictor.
//   - The predictor keeps its own copy of the map bits and of the registers and
//     queues the neighbour words that an expand word must produce.
//   - One clocked process drives the result ready line (random stall bursts, or
//     a long hold-off while the stall test runs) and compares every word taken
//     against the oldest queued prediction.
//   - Registers go through the APB-style port only when the block is drained.
// The map is undefined after reset, so every in-extent neighbour of a cell is
// written before that cell is expanded.
module tb_grid_neighbor_expander;
  import gne_pkg::*;

  localparam int CLK_HALF_NS   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_NS      = 6_000_000;
  localparam int MAP_SIDE      = GNE_MAX_DIM;
  localparam int MAP_CELLS     = MAP_SIDE * MAP_SIDE;
  localparam int WINDOW        = 12;
  localparam int MAX_REPORTS   = 10;

  // Register indexes of the configuration port
  localparam int REG_GRID_WIDTH    = 0;
  localparam int REG_GRID_HEIGHT   = 1;
  localparam int REG_DIAG_ENABLE   = 2;
  localparam int REG_STRAIGHT_COST = 3;
  localparam int REG_DIAGONAL_COST = 4;

  // Neighbour order: right, down, left, up, down-right, down-left, up-left, up-right
  localparam int STEP_DX [8] = '{1, 0, -1, 0, 1, -1, -1, 1};
  localparam int STEP_DY [8] = '{0, 1, 0, -1, 1, 1, -1, -1};
  // Orthogonal neighbours that must both be open for each diagonal
  localparam int GATE_A [4] = '{0, 2, 2, 0};
  localparam int GATE_B [4] = '{1, 1, 3, 3};

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [GNE_PADDR_W-1:0] paddr;
  logic [GNE_PDATA_W-1:0] pwdata;
  logic [GNE_PDATA_W-1:0] prdata;
  logic                   pready;

  gne_req_if req_if ();
  gne_rsp_if rsp_if ();

  grid_neighbor_expander u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // Predictor state
  bit       map_blocked [MAP_CELLS];
  bit       map_written [MAP_CELLS];
  gne_cfg_t cfg;
  gne_rsp_t pending_neighbours [$];

  // Run bookkeeping
  bit idle_on  = 1'b1;
  bit rsp_hold = 1'b0;
  int stall_left;
  int base_x;
  int base_y;
  int words_sent;
  int map_writes;
  int expansions;
  int results_checked;
  int config_writes;
  int error_count;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Coordinates are 8 bits, so nothing past 256 is ever usable
  function automatic int extent_of(logic [8:0] span);
    return (span > 9'd256) ? 256 : int'(span);
  endfunction

  function automatic bit in_extent(int x, int y);
    return x >= 0 && y >= 0 &&
           x < extent_of(cfg.grid_width) && y < extent_of(cfg.grid_height);
  endfunction

  function automatic bit cell_blocked(int x, int y);
    if (!in_extent(x, y)) return 1'b1;
    return map_blocked[x * MAP_SIDE + y];
  endfunction

  function automatic int abs_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Append one predicted word at the tail of the queue
  function automatic void queue_word(gne_rsp_t r);
    pending_neighbours.insert(pending_neighbours.size(), r);
  endfunction

  // Queue the words one expand produces, in emission order
  function automatic void expand_neighbours(gne_req_t w);
    bit       open [8];
    int       nx;
    int       ny;
    int       n;
    int       score;
    gne_rsp_t r;
    n = 0;
    for (int k = 0; k < 8; k++) begin
      open[k] = !cell_blocked(int'(w.cell_x) + STEP_DX[k], int'(w.cell_y) + STEP_DY[k]);
      if (k >= 4) begin
        open[k] = open[k] && cfg.diagonal_enable && open[GATE_A[k-4]] && open[GATE_B[k-4]];
      end
    end
    for (int k = 0; k < 8; k++) begin
      if (open[k]) begin
        nx = int'(w.cell_x) + STEP_DX[k];
        ny = int'(w.cell_y) + STEP_DY[k];
        score = (abs_gap(int'(w.target_x), nx) + abs_gap(int'(w.target_y), ny)) *
                int'(cfg.straight_cost);
        r.found      = 1'b1;
        r.neighbor_x = nx[7:0];
        r.neighbor_y = ny[7:0];
        r.step_cost  = (k < 4) ? cfg.straight_cost : cfg.diagonal_cost;
        r.estimate   = score[16:0];
        r.last       = 1'b0;
        queue_word(r);
        n++;
      end
    end
    if (n == 0) begin
      // Dead end: a single empty word closes the expansion
      r = '0;
      r.last = 1'b1;
      queue_word(r);
    end else begin
      pending_neighbours[pending_neighbours.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void apply_word(gne_req_t w);
    int idx;
    idx = int'(w.cell_x) * MAP_SIDE + int'(w.cell_y);
    if (w.kind == GNE_KIND_WRITE) begin
      map_blocked[idx] = (w.cell_value == GNE_BLOCKED_CODE);
      map_written[idx] = 1'b1;
      map_writes++;
    end else begin
      expand_neighbours(w);
      expansions++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready generation and checking
  // ---------------------------------------------------------------------------

  function automatic string rsp_text(gne_rsp_t r);
    return $sformatf("found=%0d x=%0d y=%0d cost=%0d est=%0d last=%0d",
                     r.found, r.neighbor_x, r.neighbor_y, r.step_cost, r.estimate, r.last);
  endfunction

  function automatic void check_result(gne_rsp_t got);
    gne_rsp_t want;
    results_checked++;
    if (pending_neighbours.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("[%0t] result word with nothing pending: %s", $realtime, rsp_text(got));
      end
      return;
    end
    want = pending_neighbours.pop_front();
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("[%0t] result mismatch", $realtime);
        $display("  expected %s", rsp_text(want));
        $display("  actual   %s", rsp_text(got));
      end
    end
  endfunction

  // Sample at the edge, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      check_result(rsp_if.data);
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (rsp_hold) begin
      rsp_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      // start a burst with ready held low
      stall_left = $urandom_range(0, 2);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Hold valid high across back-to-back words; drop it only for an idle burst
  task automatic send_word(gne_req_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    do @(posedge clk_i); while (!req_if.ready);
    apply_word(w);
    words_sent++;
  endtask

  // Drop valid and wait for every predicted word plus the block's tail
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_neighbours.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int random_map_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'(GNE_BLOCKED_CODE);
      4, 5, 6:    return 0;
      default:    return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic write_cell(int x, int y, int value);
    gne_req_t w;
    w.kind       = GNE_KIND_WRITE;
    w.cell_x     = x[7:0];
    w.cell_y     = y[7:0];
    w.cell_value = value[7:0];
    w.target_x   = 8'($urandom_range(0, 255));
    w.target_y   = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  // Expand a cell after writing any in-extent neighbour that was never written;
  // a negative fill picks a random map byte per neighbour
  task automatic expand_at(int x, int y, int tx, int ty, int fill);
    gne_req_t w;
    int       nx;
    int       ny;
    for (int k = 0; k < 8; k++) begin
      nx = x + STEP_DX[k];
      ny = y + STEP_DY[k];
      if (in_extent(nx, ny) && !map_written[nx * MAP_SIDE + ny]) begin
        write_cell(nx, ny, (fill < 0) ? random_map_byte() : fill);
      end
    end
    w.kind       = GNE_KIND_EXPAND;
    w.cell_x     = x[7:0];
    w.cell_y     = y[7:0];
    w.cell_value = 8'($urandom_range(0, 255));
    w.target_x   = tx[7:0];
    w.target_y   = ty[7:0];
    send_word(w);
  endtask

  // Setup then access phase; the register takes the word when pready is seen
  task automatic apb_write(int idx, int field_w, int value);
    logic [GNE_PADDR_W-1:0] addr;
    logic [GNE_PDATA_W-1:0] data;
    logic [GNE_PDATA_W-1:0] mask;
    addr = GNE_PADDR_W'(idx * 4);
    mask = (32'd1 << field_w) - 32'd1;
    data = value & mask;
    if ($urandom_range(0, 1) == 1) begin
      data = data | ($urandom & ~mask);  // stray upper bits must be ignored
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:    cfg.grid_width      = data[8:0];
      REG_GRID_HEIGHT:   cfg.grid_height     = data[8:0];
      REG_DIAG_ENABLE:   cfg.diagonal_enable = data[0];
      REG_STRAIGHT_COST: cfg.straight_cost   = data[7:0];
      REG_DIAGONAL_COST: cfg.diagonal_cost   = data[7:0];
      default: ;
    endcase
    config_writes++;
  endtask

  task automatic set_config(int gw, int gh, int diag, int straight, int diagonal);
    settle();
    apb_write(REG_GRID_WIDTH, 9, gw);
    apb_write(REG_GRID_HEIGHT, 9, gh);
    apb_write(REG_DIAG_ENABLE, 1, diag);
    apb_write(REG_STRAIGHT_COST, 8, straight);
    apb_write(REG_DIAGONAL_COST, 8, diagonal);
    @(posedge clk_i);
  endtask

  // Window origin: hug the near edge, the far edge, or land anywhere
  function automatic int window_base(int span);
    if (span <= WINDOW) return 0;
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return span - WINDOW;
      default: return $urandom_range(0, span - WINDOW);
    endcase
  endfunction

  // Mostly inside the window; sometimes the last row, just outside, or anywhere
  function automatic int pick_coord(int span, int base);
    int c;
    case ($urandom_range(0, 9))
      0:       c = $urandom_range(0, 255);
      1:       c = (span > 0) ? span - 1 : 0;
      2:       c = span;
      default: c = base + $urandom_range(0, WINDOW);
    endcase
    return (c > 255) ? 255 : c;
  endfunction

  task automatic run_random_words(int n_words);
    int stop_at;
    int span_x;
    int span_y;
    span_x  = extent_of(cfg.grid_width);
    span_y  = extent_of(cfg.grid_height);
    base_x  = window_base(span_x);
    base_y  = window_base(span_y);
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) < 3) begin
        write_cell(pick_coord(span_x, base_x), pick_coord(span_y, base_y), random_map_byte());
      end else begin
        expand_at(pick_coord(span_x, base_x), pick_coord(span_y, base_y),
                  $urandom_range(0, 255), $urandom_range(0, 255), -1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: three corners of the full map
  task automatic test_corner_expansion();
    write_cell(1, 0, 0);
    write_cell(0, 1, 255);
    write_cell(1, 1, 2);
    expand_at(0, 0, 255, 255, 0);                        // right, down, down-right
    expand_at(255, 255, 0, 0, 0);                        // left, up, up-left
    expand_at(255, 0, 0, 255, int'(GNE_BLOCKED_CODE));   // walled in at the corner
  endtask

  // Fully walled cell, then open the ring piece by piece to exercise the gating
  task automatic test_blocked_and_gating();
    for (int k = 0; k < 8; k++) begin
      write_cell(128 + STEP_DX[k], 128 + STEP_DY[k], int'(GNE_BLOCKED_CODE));
    end
    expand_at(128, 128, 128, 128, 0);               // no open neighbour
    write_cell(129, 128, 0);
    expand_at(128, 128, 0, 0, 0);                   // right only
    write_cell(128, 129, 0);
    expand_at(128, 128, 255, 255, 0);               // diagonal still walled
    write_cell(129, 129, 0);
    expand_at(128, 128, 255, 0, 0);                 // right, down, down-right
  endtask

  task automatic test_register_extremes();
    set_config(256, 256, 0, 255, 255);
    expand_at(128, 128, 0, 0, 0);                   // four-connected, top costs
    set_config(0, 256, 1, 10, 14);
    expand_at(5, 5, 9, 9, 0);                       // zero width blocks all
    set_config(256, 0, 1, 10, 14);
    expand_at(5, 5, 9, 9, 0);                       // zero height blocks all
    set_config(4, 4, 1, 0, 255);
    expand_at(4, 2, 0, 0, 0);                       // centre past the edge
    expand_at(200, 200, 0, 0, 0);                   // far outside
    set_config(511, 300, 1, 255, 0);
    expand_at(255, 128, 0, 0, 0);                   // oversized extent clips at 256
    expand_at(0, 255, 255, 0, 0);
  endtask

  // Several register settings, extremes among them, each with random traffic
  task automatic test_random_settings();
    int gw [8] = '{256, 8, 1, 511, 0, 2, 300, 16};
    int gh [8] = '{256, 8, 256, 511, 5, 1, 257, 3};
    int straight;
    int diagonal;
    for (int p = 0; p < 8; p++) begin
      straight = (p == 3) ? 255 : (p == 7) ? 0 : $urandom_range(0, 255);
      diagonal = (p == 3) ? 255 : (p == 7) ? 0 : $urandom_range(0, 255);
      set_config(gw[p], gh[p], (p % 3 == 2) ? 0 : 1, straight, diagonal);
      run_random_words(45);
    end
  endtask

  // Hold the result side off while words keep coming, so the input backs up
  task automatic test_output_stall();
    set_config(32, 32, 1, $urandom_range(0, 255), $urandom_range(0, 255));
    fork
      begin
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rsp_hold <= 1'b0;
      end
      run_random_words(40);
    join
  endtask

  // Closing stretch with no idling on either side
  task automatic test_full_rate();
    set_config(10, 10, 1, $urandom_range(0, 255), $urandom_range(0, 255));
    idle_on = 1'b0;
    run_random_words(80);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    cfg.grid_width      = GNE_RST_GRID_WIDTH;
    cfg.grid_height     = GNE_RST_GRID_HEIGHT;
    cfg.diagonal_enable = GNE_RST_DIAG_ENABLE;
    cfg.straight_cost   = GNE_RST_STRAIGHT_COST;
    cfg.diagonal_cost   = GNE_RST_DIAGONAL_COST;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_corner_expansion();
    test_blocked_and_gating();
    test_register_extremes();
    test_random_settings();
    test_output_stall();
    test_full_rate();
    settle();

    $display("covered %0d words: %0d map writes and %0d expansions, %0d results checked",
             words_sent, map_writes, expansions, results_checked);
    $display("%0d register writes across extreme extents and costs, one %0d-cycle hold-off",
             config_writes, HOLD_CYCLES);
    if (error_count == 0 && pending_neighbours.size() == 0) begin
      $display("grid_neighbor_expander regression: pass");
    end else begin
      $display("%0d errors, %0d results still pending", error_count, pending_neighbours.size());
      $display("grid_neighbor_expander regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results pending", pending_neighbours.size());
    $display("grid_neighbor_expander regression: fail");
    $finish;
  end

endmodule

/* grid_neighbor_expander.f */
sv/gne_pkg.sv
sv/gne_req_if.sv
sv/gne_rsp_if.sv
sv/gne_cfg_regs.sv
sv/grid_neighbor_expander.sv
verif/tb_grid_neighbor_expander.sv
